FILE: rtl/fba_pkg.sv
// Shared types and constants for the frame bitmap allocator.
// Used by fba_ctrl, fba_dpath and frame_bitmap_allocator; no dependencies.
package fba_pkg;

  localparam int ADDR_W    = 32;
  localparam int CFG_W     = 16;
  localparam int KIND_W    = 2;
  localparam int OUT_CNT_W = 16;

  localparam int DEF_NUM_FRAMES  = 32768;
  localparam int DEF_FRAME_SHIFT = 12;
  localparam int ACTIVE_RESET    = 32768;

  localparam logic [KIND_W-1:0] KIND_ALLOC      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE_RANGE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESERVE    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;      // write all-ones at sweep pointer
    logic take;        // latch the input transaction
    logic setup;       // compute walk bounds
    logic alloc_fail;  // mark allocation failed
    logic rd_cur;      // read bitmap word under cursor
    logic alloc_skip;  // word fully used, move to next
    logic alloc_wr;    // mark found frame, count up
    logic range_wr;    // masked set/clear of one word
    logic rd_w0;       // read word 0
    logic fix0_wr;     // set frame 0
    logic out_load;    // move result to output register
  } fba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_last;
    logic is_alloc;
    logic is_free_range;
    logic full;
    logic at_end;
    logic word_full;
    logic hit_ok;
  } fba_stat_t;

endpackage

FILE: rtl/frame_bitmap_allocator.sv
// Top level of the frame bitmap allocator: ties fba_ctrl to fba_dpath.
// Depends on fba_pkg, fba_ctrl and fba_dpath.
//
// Input channel (in_valid/in_stall): one request per transaction, kind
// (allocate, release frame, release range, reserve range) with base_address
// and length_bytes in bytes; a frame is 2^FRAME_SHIFT bytes.
// Output channel (out_valid/out_stall): one transaction per request with
// frame_address (allocated address, else 0), status (1 = failed allocation)
// and used_count (used frames after the request).
// cfg_wr_en/cfg_wr_data write active_frames; write only while idle.
// Sequencing: one request at a time. Each bitmap word visited takes a
// registered read, then a modify/write, after setup and before hand-off.
// Allocation visits words from 0 up to the first one with a free frame;
// ranges visit every word they touch; release frame touches at most one
// word; release range then reads word 0 and re-marks frame 0.
// Reset: the bitmap is swept to all-used, one word per cycle, with in_stall
// high; the used count resets to NUM_FRAMES.
// Back pressure: a finished result waits in the output register; the next
// request is still accepted and processed, only its own hand-off waits.
module frame_bitmap_allocator import fba_pkg::*; #(
  parameter int NUM_FRAMES  = DEF_NUM_FRAMES,
  parameter int FRAME_SHIFT = DEF_FRAME_SHIFT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_W-1:0]    kind,
  input  logic [ADDR_W-1:0]    base_address,
  input  logic [ADDR_W-1:0]    length_bytes,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    frame_address,
  output logic                 status,
  output logic [OUT_CNT_W-1:0] used_count
);

  fba_cmd_t  cmd;
  fba_stat_t stat;

  // sequencer: owns handshakes and the clearing pass
  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // bitmap memory, cursor, counter and result register
  fba_dpath #(
    .NUM_FRAMES  (NUM_FRAMES),
    .FRAME_SHIFT (FRAME_SHIFT)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .kind          (kind),
    .base_address  (base_address),
    .length_bytes  (length_bytes),
    .cmd           (cmd),
    .stat          (stat),
    .frame_address (frame_address),
    .status        (status),
    .used_count    (used_count)
  );

endmodule

FILE: rtl/fba_dpath.sv
// Datapath of the frame bitmap allocator: bitmap memory, walk cursor,
// used-frame counter, limit register and output register. Uses fba_pkg.
module fba_dpath import fba_pkg::*; #(
  parameter int NUM_FRAMES  = DEF_NUM_FRAMES,
  parameter int FRAME_SHIFT = DEF_FRAME_SHIFT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic [KIND_W-1:0]    kind,
  input  logic [ADDR_W-1:0]    base_address,
  input  logic [ADDR_W-1:0]    length_bytes,
  input  fba_cmd_t             cmd,
  output fba_stat_t            stat,
  output logic [ADDR_W-1:0]    frame_address,
  output logic                 status,
  output logic [OUT_CNT_W-1:0] used_count
);

  localparam int WORDS   = (NUM_FRAMES + 31) / 32;
  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
  localparam int PTR_W   = CNT_W + 1;
  localparam int FI_W    = ADDR_W - FRAME_SHIFT;
  localparam int SW      = (FI_W + 1 > PTR_W) ? FI_W + 1 : PTR_W;
  localparam int LW      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int LIM_RST = (ACTIVE_RESET < NUM_FRAMES) ? ACTIVE_RESET : NUM_FRAMES;

  logic [31:0]       bitmap [WORDS];
  logic [31:0]       rd_data;
  logic [AW-1:0]     sweep_ptr;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  used;
  logic [KIND_W-1:0] kind_r;
  logic [FI_W-1:0]   start_f;
  logic [FI_W:0]     sum_f;
  logic [PTR_W-1:0]  cur;
  logic [PTR_W-1:0]  end_f;
  logic [ADDR_W-1:0] res_addr;
  logic              res_status;

  // input latch
  logic [FI_W-1:0] cnt_raw, cnt_sel;
  logic            base_nz;
  assign cnt_raw = length_bytes[ADDR_W-1:FRAME_SHIFT];
  assign base_nz = (base_address != '0);
  always_comb begin
    case (kind)
      KIND_FREE:    cnt_sel = base_nz ? FI_W'(1) : '0;
      KIND_RESERVE: cnt_sel = (cnt_raw == '0) ? FI_W'(1) : cnt_raw;
      default:      cnt_sel = cnt_raw;
    endcase
  end

  // walk bounds: end = min(start + count, limit)
  logic [SW-1:0] start_x, sum_x, lim_x, end_x;
  logic          empty;
  assign start_x = SW'(start_f);
  assign sum_x   = SW'(sum_f);
  assign lim_x   = SW'(limit);
  assign end_x   = (sum_x < lim_x) ? sum_x : lim_x;
  assign empty   = (start_x >= end_x);

  // one word under the cursor
  logic [PTR_W-1:0] wbase, wnext, seg_end;
  logic             top_full;
  logic [5:0]       n_seg, n_step;
  logic [31:0]      lo_mask, hi_mask, seg_mask;
  logic [AW-1:0]    cur_word;
  assign wbase    = {cur[PTR_W-1:5], 5'd0};
  assign wnext    = wbase + PTR_W'(32);
  assign top_full = (end_f >= wnext);
  assign seg_end  = top_full ? wnext : end_f;
  assign n_seg    = 6'(seg_end - cur);
  assign lo_mask  = 32'hFFFF_FFFF << cur[4:0];
  assign hi_mask  = top_full ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << end_f[4:0]);
  assign seg_mask = lo_mask & hi_mask;
  assign cur_word = cur[AW+4:5];
  assign n_step   = cmd.alloc_wr ? 6'd1 : n_seg;

  // lowest clear bit of the word read
  logic [4:0]       zb;
  logic [PTR_W-1:0] hit_f;
  always_comb begin
    zb = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!rd_data[i]) zb = 5'(i);
    end
  end
  assign hit_f = {cur[PTR_W-1:5], zb};

  // saturating counter updates
  logic [CNT_W:0]   up_sum;
  logic [CNT_W-1:0] cnt_up, cnt_dn;
  assign up_sum = {1'b0, used} + (CNT_W+1)'(n_step);
  assign cnt_up = (used >= limit) ? used :
                  (up_sum > {1'b0, limit}) ? limit : up_sum[CNT_W-1:0];
  assign cnt_dn = (used > CNT_W'(n_step)) ? used - CNT_W'(n_step) : '0;

  // memory port control
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data;
  assign wr_en   = cmd.clr_wr | cmd.alloc_wr | cmd.range_wr | cmd.fix0_wr;
  assign rd_en   = cmd.rd_cur | cmd.rd_w0;
  assign rd_addr = cmd.rd_w0 ? '0 : cur_word;
  assign wr_addr = cmd.clr_wr ? sweep_ptr : (cmd.fix0_wr ? '0 : cur_word);
  always_comb begin
    if (cmd.clr_wr) begin
      wr_data = 32'hFFFF_FFFF;
    end else if (cmd.alloc_wr) begin
      wr_data = rd_data | (32'd1 << zb);
    end else if (cmd.range_wr) begin
      wr_data = (kind_r == KIND_RESERVE) ? (rd_data | seg_mask) : (rd_data & ~seg_mask);
    end else begin
      wr_data = rd_data | 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) bitmap[wr_addr] <= wr_data;
    if (rd_en) rd_data <= bitmap[rd_addr];
  end

  // control state
  logic [LW-1:0] cfg_x, nf_x;
  assign cfg_x = LW'(cfg_wr_data);
  assign nf_x  = LW'(NUM_FRAMES);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_ptr <= '0;
      limit     <= CNT_W'(LIM_RST);
      used      <= CNT_W'(NUM_FRAMES);
    end else begin
      if (cmd.clr_wr) sweep_ptr <= sweep_ptr + AW'(1);
      if (cfg_wr_en) limit <= CNT_W'((cfg_x < nf_x) ? cfg_x : nf_x);
      if (cmd.alloc_wr || (cmd.range_wr && kind_r == KIND_RESERVE)) begin
        used <= cnt_up;
      end else if (cmd.range_wr) begin
        used <= cnt_dn;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r     <= kind;
      start_f    <= base_address[ADDR_W-1:FRAME_SHIFT];
      sum_f      <= {1'b0, base_address[ADDR_W-1:FRAME_SHIFT]} + {1'b0, cnt_sel};
      res_addr   <= '0;
      res_status <= 1'b0;
    end
    if (cmd.setup) begin
      if (kind_r == KIND_ALLOC) begin
        cur   <= '0;
        end_f <= {1'b0, limit};
      end else begin
        end_f <= PTR_W'(end_x);
        cur   <= empty ? PTR_W'(end_x) : PTR_W'(start_f);
      end
    end
    if (cmd.alloc_skip) cur <= wnext;
    if (cmd.range_wr) cur <= seg_end;
    if (cmd.alloc_wr) res_addr <= ADDR_W'(hit_f) << FRAME_SHIFT;
    if (cmd.alloc_fail) res_status <= 1'b1;
    if (cmd.out_load) begin
      frame_address <= res_addr;
      status        <= res_status;
      used_count    <= OUT_CNT_W'(used);
    end
  end

  assign stat.sweep_last    = (sweep_ptr == AW'(WORDS - 1));
  assign stat.is_alloc      = (kind_r == KIND_ALLOC);
  assign stat.is_free_range = (kind_r == KIND_FREE_RANGE);
  assign stat.full          = (used >= limit);
  assign stat.at_end        = (cur >= end_f);
  assign stat.word_full     = (&rd_data);
  assign stat.hit_ok        = (hit_f < end_f);

endmodule

FILE: rtl/fba_ctrl.sv
// Sequencer of the frame bitmap allocator: clearing pass, word walk and
// output handshake. Uses fba_pkg; drives fba_dpath through fba_cmd_t.
module fba_ctrl import fba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  fba_stat_t stat,
  output fba_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_MODIFY = 3'd4;
  localparam logic [2:0] S_FIX_RD = 3'd5;
  localparam logic [2:0] S_FIX_WR = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state, state_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        if (stat.is_alloc && stat.full) begin
          cmd.alloc_fail = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.setup  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.at_end) begin
          cmd.rd_cur = 1'b1;
          state_next = S_MODIFY;
        end else if (stat.is_alloc) begin
          cmd.alloc_fail = 1'b1;
          state_next     = S_DONE;
        end else if (stat.is_free_range) begin
          state_next = S_FIX_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MODIFY: begin
        if (!stat.is_alloc) begin
          cmd.range_wr = 1'b1;
          state_next   = S_CHECK;
        end else if (stat.word_full) begin
          cmd.alloc_skip = 1'b1;
          state_next     = S_CHECK;
        end else if (stat.hit_ok) begin
          cmd.alloc_wr = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.alloc_fail = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_FIX_RD: begin
        cmd.rd_w0  = 1'b1;
        state_next = S_FIX_WR;
      end
      S_FIX_WR: begin
        cmd.fix0_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_wr, cmd.alloc_wr, cmd.range_wr, cmd.fix0_wr}))
    else $error("more than one bitmap write in a cycle");

  a_read_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_MODIFY) |-> ($past(state) == S_CHECK))
    else $error("word modified without a preceding read");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> (state == S_DONE))
    else $error("result overwrote an unaccepted transaction");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

FILE: test/frame_bitmap_allocator_tb.sv
// Self-checking testbench for frame_bitmap_allocator: a directed table, then random phases.
// A local bitmap predictor checks every result. Depends on fba_pkg and the RTL under rtl/.
module frame_bitmap_allocator_tb;
  import fba_pkg::*;

  localparam int NUM_FRAMES  = DEF_NUM_FRAMES;
  localparam int FRAME_SHIFT = DEF_FRAME_SHIFT;
  localparam int PLAN_ROWS   = 27;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [ADDR_W-1:0]    addr;
    logic                 status;
    logic [OUT_CNT_W-1:0] count;
  } frame_result_t;

  // One directed transaction. An optional limit write goes ahead of it. The expected
  // result is typed in only where it is obvious; otherwise the predictor supplies it.
  typedef struct packed {
    logic              set_cfg;
    logic [CFG_W-1:0]  cfg;
    logic [KIND_W-1:0] op;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic              typed;
    frame_result_t     want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    kind = KIND_ALLOC;
  logic [ADDR_W-1:0]    base_address = '0;
  logic [ADDR_W-1:0]    length_bytes = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_W-1:0]    frame_address;
  logic                 status;
  logic [OUT_CNT_W-1:0] used_count;

  always #10 clk = ~clk;

  frame_bitmap_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .base_address (base_address),
    .length_bytes (length_bytes),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_address(frame_address),
    .status       (status),
    .used_count   (used_count)
  );

  // Predictor state: usage bit per frame, used count, active_frames register.
  bit            frame_busy [NUM_FRAMES];
  int unsigned   frames_used = NUM_FRAMES;
  int unsigned   active_setting = ACTIVE_RESET;

  frame_result_t pending_results [$];
  plan_row_t     plan [PLAN_ROWS];

  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned allocs_failed = 0;
  int unsigned limit_writes = 0;
  int unsigned mismatches = 0;
  bit          send_calm = 1'b0;

  initial begin
    foreach (frame_busy[i]) frame_busy[i] = 1'b1;
  end

  // Applies one request to the local bitmap and returns the result it must produce.
  function automatic frame_result_t apply_request(input logic [KIND_W-1:0] op,
                                                  input logic [ADDR_W-1:0] b,
                                                  input logic [ADDR_W-1:0] l);
    frame_result_t r;
    int unsigned   lim, first, span, stop, f;
    r = '0;
    lim = (active_setting < NUM_FRAMES) ? active_setting : NUM_FRAMES;
    first = b >> FRAME_SHIFT;
    span = l >> FRAME_SHIFT;
    case (op)
      KIND_ALLOC: begin
        // store full fails before any search
        f = 0;
        if (frames_used < lim)
          while (f < lim && frame_busy[f]) f++;
        if (frames_used >= lim || f >= lim) begin
          r.status = 1'b1;
          allocs_failed++;
        end else begin
          frame_busy[f] = 1'b1;
          frames_used++;
          r.addr = f << FRAME_SHIFT;
        end
      end
      KIND_FREE: begin
        if (b != 0 && first < lim) begin
          frame_busy[first] = 1'b0;
          if (frames_used > 0) frames_used--;
        end
      end
      KIND_FREE_RANGE: begin
        stop = first + span;
        if (stop > lim) stop = lim;
        for (f = first; f < stop; f++) begin
          frame_busy[f] = 1'b0;
          if (frames_used > 0) frames_used--;
        end
        // frame 0 stays reserved, count untouched
        frame_busy[0] = 1'b1;
      end
      default: begin
        if (span == 0) span = 1;
        stop = first + span;
        if (stop > lim) stop = lim;
        for (f = first; f < stop; f++) begin
          frame_busy[f] = 1'b1;
          if (frames_used < lim) frames_used++;
        end
      end
    endcase
    r.count = frames_used[OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t row(input logic set_cfg, input logic [CFG_W-1:0] cfg,
                                    input logic [KIND_W-1:0] op, input logic [ADDR_W-1:0] b,
                                    input logic [ADDR_W-1:0] l, input logic typed,
                                    input logic [ADDR_W-1:0] a, input logic s,
                                    input logic [OUT_CNT_W-1:0] c);
    plan_row_t p;
    p.set_cfg = set_cfg;
    p.cfg = cfg;
    p.op = op;
    p.base = b;
    p.len = l;
    p.typed = typed;
    p.want.addr = a;
    p.want.status = s;
    p.want.count = c;
    return p;
  endfunction

  // Offers one transaction after a random gap, waits for acceptance, then records the
  // expected result.
  task automatic send_request(input logic [KIND_W-1:0] op, input logic [ADDR_W-1:0] b,
                              input logic [ADDR_W-1:0] l, input logic typed,
                              input frame_result_t want);
    int unsigned   gap;
    frame_result_t r;
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    base_address <= b;
    length_bytes <= l;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = apply_request(op, b, l);
    if (typed) r = want;
    pending_results.push_back(r);
    requests_sent++;
  endtask

  // active_frames is written only once the block has gone quiet.
  task automatic change_limit(input logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_setting = v;
    limit_writes++;
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] cfg, input int unsigned n);
    int unsigned       lim, fr, pick, i;
    logic [KIND_W-1:0] op;
    logic [ADDR_W-1:0] b, l;
    frame_result_t     none;
    none = '0;
    change_limit(cfg);
    lim = (cfg < NUM_FRAMES) ? cfg : NUM_FRAMES;
    // half the phases open by freeing everything so allocations can succeed
    if ($urandom_range(0, 1) == 0)
      send_request(KIND_FREE_RANGE, '0, '1, 1'b0, none);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = KIND_ALLOC;
      else if (pick < 65) op = KIND_FREE;
      else if (pick < 80) op = KIND_FREE_RANGE;
      else op = KIND_RESERVE;
      // frames from 0 up to eight past the limit, often with noise in the offset bits
      fr = $urandom_range(0, lim + 8);
      b = (fr << FRAME_SHIFT) | ($urandom & ((1 << FRAME_SHIFT) - 1));
      if ($urandom_range(0, 3) == 0) b = fr << FRAME_SHIFT;
      if ($urandom_range(0, 9) == 0) b = $urandom;
      l = ($urandom_range(0, 12) << FRAME_SHIFT) | ($urandom & ((1 << FRAME_SHIFT) - 1));
      if ($urandom_range(0, 19) == 0) l = $urandom;
      send_request(op, b, l, 1'b0, none);
    end
  endtask

  // Result checker: every accepted output transaction is matched to the oldest expectation.
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected result, expected none got addr %0h status %0h count %0d",
                   $time, frame_address, status, used_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (frame_address !== want.addr) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: frame_address expected %0h got %0h", $time, want.addr,
                     frame_address);
          mismatches++;
        end
        if (status !== want.status) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: status expected %0h got %0h", $time, want.status, status);
          mismatches++;
        end
        if (used_count !== want.count) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: used_count expected %0d got %0d", $time, want.count, used_count);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stall before each result, calm stretches, and one long hold-off
  // that backs the block up into its input.
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    bit          calm;
    bit          pressed;
    taken = 0;
    calm = 1'b0;
    pressed = 1'b0;
    forever begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 7);
      if (!pressed && taken == 600) begin
        hold = 400;
        pressed = 1'b1;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !rst));
      taken++;
    end
  end

  initial begin : stimulus
    int unsigned i;

    // directed table; the reset state is every frame used with the count at 32768
    plan[0]  = row(1, 16'd32768, KIND_ALLOC, 32'h0, 32'h0, 1, 32'h0, 1, 16'd32768);
    plan[1]  = row(0, 16'd0, KIND_FREE, 32'h0, 32'h0, 1, 32'h0, 0, 16'd32768);
    plan[2]  = row(0, 16'd0, KIND_FREE, 32'h1000, 32'h0, 1, 32'h0, 0, 16'd32767);
    plan[3]  = row(0, 16'd0, KIND_ALLOC, 32'h0, 32'h0, 1, 32'h1000, 0, 16'd32768);
    plan[4]  = row(0, 16'd0, KIND_FREE, 32'hFFF, 32'h0, 1, 32'h0, 0, 16'd32767);
    plan[5]  = row(0, 16'd0, KIND_ALLOC, 32'h0, 32'h0, 1, 32'h0, 0, 16'd32768);
    // double release: count drops twice, only one bit clears
    plan[6]  = row(0, 16'd0, KIND_FREE, 32'h2000, 32'h0, 0, 32'h0, 0, 16'd0);
    plan[7]  = row(0, 16'd0, KIND_FREE, 32'h2000, 32'h0, 0, 32'h0, 0, 16'd0);
    plan[8]  = row(0, 16'd0, KIND_ALLOC, 32'h0, 32'h0, 0, 32'h0, 0, 16'd0);
    plan[9]  = row(0, 16'd0, KIND_ALLOC, 32'h0, 32'h0, 0, 32'h0, 0, 16'd0);
    // free everything: count floors at 0, frame 0 comes back
    plan[10] = row(0, 16'd0, KIND_FREE_RANGE, 32'h0, 32'hFFFF_FFFF, 1, 32'h0, 0, 16'd0);
    plan[11] = row(0, 16'd0, KIND_FREE_RANGE, 32'h0, 32'h0, 0, 32'h0, 0, 16'd0);
    plan[12] = row(0, 16'd0, KIND_RESERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, 0, 16'd0);
    plan[13] = row(0, 16'd0, KIND_ALLOC, 32'h0, 32'h0, 0, 32'h0, 0, 16'd0);
    plan[14] = row(0, 16'd0, KIND_RESERVE, 32'h3000, 32'h0, 0, 32'h0, 0, 16'd0);
    plan[15] = row(0, 16'd0, KIND_RESERVE, 32'h0001_0000, 32'h5FFF, 0, 32'h0, 0, 16'd0);
    // zero limit: nothing is managed
    plan[16] = row(1, 16'd0, KIND_ALLOC, 32'h0, 32'h0, 0, 32'h0, 0, 16'd0);
    plan[17] = row(0, 16'd0, KIND_FREE, 32'h1000, 32'h0, 0, 32'h0, 0, 16'd0);
    plan[18] = row(0, 16'd0, KIND_FREE_RANGE, 32'h0, 32'h0001_0000, 0, 32'h0, 0, 16'd0);
    // register above NUM_FRAMES saturates
    plan[19] = row(1, 16'hFFFF, KIND_ALLOC, 32'h0, 32'h0, 0, 32'h0, 0, 16'd0);
    plan[20] = row(0, 16'd0, KIND_FREE_RANGE, 32'h07FF_F000, 32'hFFFF, 0, 32'h0, 0, 16'd0);
    plan[21] = row(0, 16'd0, KIND_ALLOC, 32'h0, 32'h0, 0, 32'h0, 0, 16'd0);
    // ranges clipped at the limit, frames past it ignored
    plan[22] = row(1, 16'd40, KIND_RESERVE, 32'h0002_0000, 32'h0001_0000, 0, 32'h0, 0, 16'd0);
    plan[23] = row(0, 16'd0, KIND_FREE, 32'h0003_0000, 32'h0, 0, 32'h0, 0, 16'd0);
    plan[24] = row(0, 16'd0, KIND_ALLOC, 32'h0, 32'h0, 0, 32'h0, 0, 16'd0);
    plan[25] = row(1, 16'd1, KIND_ALLOC, 32'h0, 32'h0, 0, 32'h0, 0, 16'd0);
    plan[26] = row(0, 16'd0, KIND_FREE, 32'hFFFF_FFFF, 32'h0, 0, 32'h0, 0, 16'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // the block sweeps its bitmap after reset and holds off input until done
    do @(posedge clk); while (in_stall !== 1'b0);

    for (i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].set_cfg) change_limit(plan[i].cfg);
      send_request(plan[i].op, plan[i].base, plan[i].len, plan[i].typed, plan[i].want);
    end

    random_phase(16'd33, 200);
    random_phase(16'd64, 200);
    random_phase(16'd100, 200);
    random_phase(16'd0, 200);
    random_phase(16'd256, 200);
    random_phase(16'd1, 200);
    random_phase(16'd1000, 200);
    random_phase(16'd32768, 200);
    random_phase(16'hFFFF, 200);
    random_phase(16'($urandom_range(2, 2048)), 200);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d requests under %0d limit settings; %0d results compared.",
             requests_sent, limit_writes, results_checked);
    $display("Allocations refused along the way: %0d; field mismatches: %0d.",
             allocs_failed, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Worst case is every request walking the full bitmap with maximum gaps on both sides.
  initial begin : watchdog
    #300_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/fba_pkg.sv
rtl/fba_dpath.sv
rtl/fba_ctrl.sv
rtl/frame_bitmap_allocator.sv
test/frame_bitmap_allocator_tb.sv
